@@ hdl/bpc_pkg.sv @@
// Package for the barometric pressure compensation block.
// Holds the widths, fixed-point constants and the sideband struct of the design.
// No dependencies.
package bpc_pkg;

    localparam int RAW_T_W   = 16;
    localparam int RAW_P_W   = 24;
    localparam int CAL_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int TEMP_W    = 17;
    localparam int PRESS_W   = 22;
    localparam int Q_W       = 23;
    localparam int DEN_W     = 64;
    localparam int REM_W     = 88;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL3 = 2'd3;

    localparam logic [27:0] LUT_LOWER_Q3 = 28'd29360128;
    localparam logic [27:0] LUT_UPPER_Q3 = 28'd96468992;
    localparam logic [24:0] P_MID_Q4     = 25'd1280000;
    localparam logic [19:0] P_SPAN2_Q4   = 20'd800000;
    localparam logic [24:0] PRESS_MAX    = 25'd4194303;
    localparam logic [16:0] TEMP_OFFSET  = 17'd11520;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              pos;
        logic              zero;
        logic              big;
    } t_side;

endpackage

@@ hdl/bpc_div_stage.sv @@
// One registered step of the restoring divider for the pressure quotient.
// Depends on bpc_pkg.
module bpc_div_stage #(
    parameter int SHIFT = 0
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [bpc_pkg::REM_W-1:0]  i_rem,
    input  logic [bpc_pkg::DEN_W-1:0]  i_den,
    input  logic [bpc_pkg::Q_W-1:0]    i_q,
    input  bpc_pkg::t_side             i_side,
    output logic [bpc_pkg::REM_W-1:0]  o_rem,
    output logic [bpc_pkg::DEN_W-1:0]  o_den,
    output logic [bpc_pkg::Q_W-1:0]    o_q,
    output bpc_pkg::t_side             o_side
);
    import bpc_pkg::*;

    logic [REM_W-1:0] w_trial;
    logic             w_take;
    logic [REM_W-1:0] n_rem;
    logic [Q_W-1:0]   n_q;
    logic [REM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_q;
    t_side            r_side;

    always_comb begin
        w_trial = REM_W'(i_den) << SHIFT;
        w_take  = (i_rem >= w_trial);
        n_rem   = w_take ? (i_rem - w_trial) : i_rem;
        n_q     = w_take ? (i_q | (Q_W'(1) << SHIFT)) : i_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_q    <= n_q;
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_q    = r_q;
    assign o_side = r_side;

endmodule

@@ hdl/baro_pressure_compensation.sv @@
// Top level of the barometric pressure compensation pipeline.
// Depends on bpc_pkg and bpc_div_stage.
//
// Usage. Each slave-side transaction carries one raw temperature code and one
// raw pressure code. Each master-side transaction returns the temperature in
// 1/256 degC, the compensated pressure in 1/16 Pa and an error flag in tuser.
// The user must write the four calibration words through the plain write port
// only while the pipeline holds no transaction; the block does not enforce it.
// The calibration words reset to zero. Throughput is one transaction per cycle
// while the master side does not stall. The pipeline has 34 register stages:
// ten stages build the three reference terms, the cross products, the
// scaled numerator and the overflow flag, 23 stages each resolve one quotient bit
// of the restoring divider, and the last stage applies the quotient about the
// mid pressure, saturates and registers the result.
// Every stage carries its own valid bit and loads only when it is empty or
// when the stage after it moves, so a stalled receiver holds the output
// register and the stages behind it close up their bubbles before the slave
// side is stalled. Nothing is lost or repeated under back-pressure.
// Reset (synchronous, active low) clears every valid bit and the calibration
// words; the data registers are left as they are.
module baro_pressure_compensation (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [bpc_pkg::CAL_W-1:0]       i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] raw_temp, [39:16] raw_press
    input  logic [39:0]                     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [16:0] temp_q8, [38:17] press_q4, [39] zero padding
    output logic [39:0]                     m_axis_tdata,
    // [0] calc_error
    output logic                            m_axis_tuser
);
    import bpc_pkg::*;

    localparam int NDIV = Q_W;
    localparam int NST  = 10 + NDIV + 1;

    // Calibration registers.
    logic [CAL_W-1:0] r_cal0, r_cal1, r_cal2, r_cal3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal0 <= '0;
            r_cal1 <= '0;
            r_cal2 <= '0;
            r_cal3 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CAL0: r_cal0 <= i_cfg_wdata;
                CFG_CAL1: r_cal1 <= i_cfg_wdata;
                CFG_CAL2: r_cal2 <= i_cfg_wdata;
                CFG_CAL3: r_cal3 <= i_cfg_wdata;
                default:  r_cal0 <= r_cal0;
            endcase
        end
    end

    // Valid bits and the advance chain: a stage loads when it is empty or
    // when the stage after it is moving on.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_adv;

    always_comb begin
        w_adv[NST-1] = !r_vld[NST-1] || m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_adv[0];

    // Stage 1: squared temperature offset and output temperature.
    logic [RAW_T_W-1:0]        w_rt;
    logic [RAW_P_W-1:0]        w_rp;
    logic signed [RAW_T_W-1:0] w_t;
    logic [23:0]               w_tscale;
    logic [30:0]               r1_tt;
    logic [TEMP_W-1:0]         r1_temp;
    logic [RAW_P_W-1:0]        r1_rp;

    always_comb begin
        w_rt     = s_axis_tdata[15:0];
        w_rp     = s_axis_tdata[39:16];
        w_t      = signed'({~w_rt[15], w_rt[14:0]});
        w_tscale = 24'(w_rt) * 24'd175 + 24'd128;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_tt   <= 31'(w_t * w_t);
            r1_temp <= TEMP_W'({1'b0, w_tscale[23:8]}) - TEMP_OFFSET;
            r1_rp   <= w_rp;
        end
    end

    // Stage 2: the three quadratic temperature products.
    logic [46:0] w_p0, w_p1, w_p2;
    logic [25:0] r2_p0, r2_p1, r2_p2;
    logic [26:0] r2_x;
    logic [TEMP_W-1:0] r2_temp;

    always_comb begin
        w_p0 = 47'(r_cal0) * 47'(r1_tt);
        w_p1 = 47'(r_cal1) * 47'(r1_tt);
        w_p2 = 47'(r_cal2) * 47'(r1_tt);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r2_p0   <= w_p0[46:21];
            r2_p1   <= w_p1[46:21];
            r2_p2   <= w_p2[46:21];
            r2_x    <= {r1_rp, 3'b000};
            r2_temp <= r1_temp;
        end
    end

    // Stage 3: reference terms S1..S3 (1/8 count) and their differences.
    logic signed [32:0] w_s1, w_s2, w_s3, w_x;
    logic signed [32:0] r3_xs3, r3_d12, r3_xs2, r3_d13;
    logic [TEMP_W-1:0]  r3_temp;

    always_comb begin
        w_s1 = signed'(33'(LUT_LOWER_Q3) + 33'(r2_p0));
        w_s2 = signed'(33'({r_cal3, 14'b0}) + 33'(r2_p1));
        w_s3 = signed'(33'(LUT_UPPER_Q3) + 33'(r2_p2));
        w_x  = signed'(33'(r2_x));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r3_xs3  <= w_x - w_s3;
            r3_d12  <= w_s1 - w_s2;
            r3_xs2  <= w_x - w_s2;
            r3_d13  <= w_s1 - w_s3;
            r3_temp <= r2_temp;
        end
    end

    // Stage 4: cross products.
    logic signed [65:0] r4_ma, r4_mb;
    logic [TEMP_W-1:0]  r4_temp;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r4_ma   <= 66'(r3_xs3) * 66'(r3_d12);
            r4_mb   <= 66'(r3_xs2) * 66'(r3_d13);
            r4_temp <= r3_temp;
        end
    end

    // Stage 5: A = 12*ma and B = 7*mb, by shifts with an add and a subtract.
    logic signed [65:0] w_a, w_b;
    logic signed [63:0] r5_a, r5_b;
    logic [TEMP_W-1:0]  r5_temp;

    always_comb begin
        w_a = (r4_ma <<< 3) + (r4_ma <<< 2);
        w_b = (r4_mb <<< 3) - r4_mb;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r5_a    <= signed'(w_a[63:0]);
            r5_b    <= signed'(w_b[63:0]);
            r5_temp <= r4_temp;
        end
    end

    // Stage 6: divisor D = A - B.
    logic signed [63:0] r6_d, r6_b;
    logic [TEMP_W-1:0]  r6_temp;

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r6_d    <= r5_a - r5_b;
            r6_b    <= r5_b;
            r6_temp <= r5_temp;
        end
    end

    // Stage 7: magnitudes, quotient sign and the zero-divisor flag.
    // Both magnitudes may reach 2^63, so they keep all 64 bits.
    logic [63:0] w_absb, w_absd;
    logic [63:0] r7_absb;
    logic [63:0] r7_absd;
    t_side       r7_side;

    always_comb begin
        w_absb = r6_b[63] ? 64'(-r6_b) : 64'(r6_b);
        w_absd = r6_d[63] ? 64'(-r6_d) : 64'(r6_d);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r7_absb      <= w_absb;
            r7_absd      <= w_absd;
            r7_side.temp <= r6_temp;
            r7_side.pos  <= (r6_b[63] == r6_d[63]);
            r7_side.zero <= (r6_d == '0);
            r7_side.big  <= 1'b0;
        end
    end

    // Stage 8: 800000*|B| as two partial products.
    logic [51:0] r8_plo;
    logic [51:0] r8_phi;
    logic [63:0] r8_absd;
    t_side       r8_side;

    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            r8_plo  <= 52'(r7_absb[31:0]) * 52'(P_SPAN2_Q4);
            r8_phi  <= 52'(r7_absb[63:32]) * 52'(P_SPAN2_Q4);
            r8_absd <= r7_absd;
            r8_side <= r7_side;
        end
    end

    // Stage 9: rounding numerator 800000*|B| + |D| over the divisor 2*|D|.
    // The divisor is kept to 64 bits, so a magnitude of 2^63 gives a zero
    // divisor and the quotient saturates.
    logic [REM_W-1:0] r9_num;
    logic [DEN_W-1:0] r9_den;
    t_side            r9_side;

    always_ff @(posedge i_clk) begin
        if (w_adv[8]) begin
            r9_num  <= (REM_W'(r8_phi) << 32) + REM_W'(r8_plo) + REM_W'(r8_absd);
            r9_den  <= {r8_absd[62:0], 1'b0};
            r9_side <= r8_side;
        end
    end

    // Stage 10: a quotient of 2^23 or more saturates on either side.
    logic [REM_W-1:0] r10_rem;
    logic [DEN_W-1:0] r10_den;
    t_side            r10_side;

    always_ff @(posedge i_clk) begin
        if (w_adv[9]) begin
            r10_rem  <= r9_num;
            r10_den  <= r9_den;
            r10_side <= {r9_side.temp, r9_side.pos, r9_side.zero,
                         (r9_num >= (REM_W'(r9_den) << Q_W))};
        end
    end

    // Divider: one quotient bit per stage, most significant first.
    logic [REM_W-1:0] w_rem  [0:NDIV];
    logic [DEN_W-1:0] w_den  [0:NDIV];
    logic [Q_W-1:0]   w_q    [0:NDIV];
    t_side            w_side [0:NDIV];

    assign w_rem[0]  = r10_rem;
    assign w_den[0]  = r10_den;
    assign w_q[0]    = '0;
    assign w_side[0] = r10_side;

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        bpc_div_stage #(
            .SHIFT (NDIV - 1 - g)
        ) u_stage (
            .i_clk  (i_clk),
            .i_en   (w_adv[10+g]),
            .i_rem  (w_rem[g]),
            .i_den  (w_den[g]),
            .i_q    (w_q[g]),
            .i_side (w_side[g]),
            .o_rem  (w_rem[g+1]),
            .o_den  (w_den[g+1]),
            .o_q    (w_q[g+1]),
            .o_side (w_side[g+1])
        );
    end

    // Output stage: apply the quotient about the mid pressure and saturate.
    t_side              w_fs;
    logic [24:0]        w_qe;
    logic [24:0]        w_lo, w_hi;
    logic [PRESS_W-1:0] n_press;
    logic               n_err;
    logic [PRESS_W-1:0] r_out_press;
    logic [TEMP_W-1:0]  r_out_temp;
    logic               r_out_err;

    always_comb begin
        w_fs = w_side[NDIV];
        w_qe = 25'(w_q[NDIV]);
        w_lo = P_MID_Q4 - w_qe;
        w_hi = P_MID_Q4 + w_qe;
        n_press = '0;
        n_err   = 1'b1;
        if (w_fs.zero) begin
            n_press = '0;
        end else if (w_fs.big) begin
            n_press = w_fs.pos ? '0 : PRESS_MAX[PRESS_W-1:0];
        end else if (w_fs.pos) begin
            if (w_lo[24]) begin
                n_press = '0;
            end else begin
                n_press = w_lo[PRESS_W-1:0];
                n_err   = 1'b0;
            end
        end else begin
            if (w_hi > PRESS_MAX) begin
                n_press = PRESS_MAX[PRESS_W-1:0];
            end else begin
                n_press = w_hi[PRESS_W-1:0];
                n_err   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[NST-1]) begin
            r_out_press <= n_press;
            r_out_temp  <= w_fs.temp;
            r_out_err   <= n_err;
        end
    end

    assign m_axis_tvalid = r_vld[NST-1];
    assign m_axis_tdata  = {1'b0, r_out_press, r_out_temp};
    assign m_axis_tuser  = r_out_err;

endmodule

@@ hdl/bpc_chk.sv @@
// Port-level checker for the barometric pressure compensation block, with its bind.
// Depends on the top level baro_pressure_compensation.
module bpc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // Nothing leaves the pipeline in the cycle after a reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // An empty output register can never back-pressure the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

    // An error always comes with a pressure pinned at one end of the range.
    a_err_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[38:17] == 22'd0 || m_axis_tdata[38:17] == 22'h3FFFFF))
        else $error("error flag without saturated pressure");

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind baro_pressure_compensation bpc_chk u_bpc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ sim/tb_baro_pressure_compensation.sv @@
// Self-checking testbench for the barometric pressure compensation pipeline.
// Depends on bpc_pkg and the baro_pressure_compensation RTL; needs no files or arguments.
// A predictor follows the three-point model; a checker compares every output transaction.
module tb_baro_pressure_compensation;
    import bpc_pkg::*;

    // Settling wait after a drain, a little longer than the pipeline is deep.
    localparam int PIPE_SETTLE = 40;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [TEMP_W-1:0]  temp_q8;
        logic [PRESS_W-1:0] press_q4;
        logic               calc_error;
    } t_reading;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CAL_W-1:0]     i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [39:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;
    logic                 m_axis_tuser;

    // Our own copy of the calibration words, updated alongside each register write.
    logic [CAL_W-1:0] cal_words [4];
    t_reading         pending_readings [$];
    int               mismatch_count = 0;
    int               cycle_count = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               recv_hold_cycles = 0;

    baro_pressure_compensation i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Compensates one raw sample pair with the current calibration words. The scaled cross
    // products wrap at 64 bits, as the hardware does, and the scaled quotient is worked
    // out at 128 bits so that it can be rounded and capped without loss. The doubled
    // divisor is kept to 64 bits; when it wraps to zero the quotient is capped.
    function automatic t_reading compensate(logic [15:0] raw_t, logic [23:0] raw_p);
        t_reading    r;
        longint      t_off, tt, s1, s2, s3, x, a, b, d, press;
        logic [63:0] bm, dm;
        logic [127:0] num, den, quot;
        r.temp_q8 = TEMP_W'(longint'((175 * raw_t + 128) >> 8) - 11520);
        t_off = longint'(raw_t) - 32768;
        tt = t_off * t_off;
        s1 = 29360128 + ((longint'(cal_words[0]) * tt) >>> 21);
        s2 = (longint'(cal_words[3]) <<< 14) + ((longint'(cal_words[1]) * tt) >>> 21);
        s3 = 96468992 + ((longint'(cal_words[2]) * tt) >>> 21);
        x = longint'(raw_p) <<< 3;
        a = 12 * ((x - s3) * (s1 - s2));
        b = 7 * ((x - s2) * (s1 - s3));
        d = a - b;
        r.calc_error = 1'b0;
        press = 0;
        if (d == 0) begin
            r.calc_error = 1'b1;
        end else begin
            bm = (b < 0) ? 64'(-b) : 64'(b);
            dm = (d < 0) ? 64'(-d) : 64'(d);
            // Round to nearest with ties away from zero: (2*400000*|b| + |d|) / (2*|d|).
            num = {64'd0, bm} * 128'd800000 + {64'd0, dm};
            den = {64'd0, dm << 1};
            if (den == 128'd0) quot = 128'd8388608;
            else quot = num / den;
            if (quot > 128'd8388608) quot = 128'd8388608;
            press = ((b < 0) == (d < 0)) ? 1280000 - longint'(quot)
                                         : 1280000 + longint'(quot);
            if (press < 0) begin
                press = 0;
                r.calc_error = 1'b1;
            end else if (press > 4194303) begin
                press = 4194303;
                r.calc_error = 1'b1;
            end
        end
        r.press_q4 = PRESS_W'(press);
        return r;
    endfunction

    // Run limit, so that a hung handshake still ends the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver ready: a long hold-off when requested, otherwise random stalls.
    always @(posedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every output transaction is compared with the oldest pending reading.
    always @(posedge i_clk) begin
        t_reading exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected output transaction: data %h user %b",
                       m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                exp_r = pending_readings.pop_front();
                if (m_axis_tdata[16:0] !== exp_r.temp_q8) begin
                    $error("temp_q8: expected %0d, actual %0d",
                           $signed(exp_r.temp_q8), $signed(m_axis_tdata[16:0]));
                    mismatch_count++;
                end
                if (m_axis_tdata[38:17] !== exp_r.press_q4) begin
                    $error("press_q4: expected %0d, actual %0d",
                           exp_r.press_q4, m_axis_tdata[38:17]);
                    mismatch_count++;
                end
                if (m_axis_tuser !== exp_r.calc_error) begin
                    $error("calc_error: expected %0b, actual %0b",
                           exp_r.calc_error, m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Offers one sample pair, idling at random first, and records the prediction once
    // the transaction is accepted. Valid stays high until a later idle or drain.
    task automatic send_sample(logic [15:0] raw_t, logic [23:0] raw_p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {raw_p, raw_t};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_readings.push_back(compensate(raw_t, raw_p));
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // Drains the pipeline, then writes all four calibration words.
    task automatic write_calibration(logic [CAL_W-1:0] w0, logic [CAL_W-1:0] w1,
                                     logic [CAL_W-1:0] w2, logic [CAL_W-1:0] w3);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CAL_W-1:0]     val [4];
        idx = '{CFG_CAL0, CFG_CAL1, CFG_CAL2, CFG_CAL3};
        val = '{w0, w1, w2, w3};
        wait_for_drain();
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= idx[k];
            i_cfg_wdata <= val[k];
            @(posedge i_clk);
            cal_words[k] = val[k];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly pressure codes around the span of the reference terms, some anywhere,
    // and a few at the ends of the field.
    task automatic send_random_sample();
        int          pick;
        logic [23:0] raw_p;
        pick = $urandom_range(99);
        if (pick < 75) raw_p = 24'($urandom_range(12500000, 3400000));
        else if (pick < 90) raw_p = 24'($urandom_range(24'hFFFFFF, 0));
        else if (pick < 95) raw_p = 24'($urandom_range(15, 0));
        else raw_p = 24'hFFFFFF - 24'($urandom_range(15, 0));
        send_sample(16'($urandom_range(65535, 0)), raw_p);
    endtask

    // Ends of both fields with the reset calibration, then with all words at maximum.
    task automatic test_field_extremes();
        logic [15:0] temps [4];
        temps = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF};
        for (int k = 0; k < 4; k++) begin
            send_sample(temps[k], 24'h000000);
            send_sample(temps[k], 24'hFFFFFF);
        end
        send_sample(16'h8000, 24'd8000000);
        write_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < 4; k++) send_sample(temps[k], 24'd6000000);
        send_sample(16'hFFFF, 24'hFFFFFF);
    endtask

    // With the middle term equal to the lower one the first cross product vanishes;
    // a pressure code at that term as well makes the divisor zero.
    task automatic test_zero_divisor();
        write_calibration(16'd0, 16'd0, 16'd0, 16'd1792);
        send_sample(16'h8000, 24'd3670016);
        send_sample(16'h8000, 24'd3670017);
        send_sample(16'h8000, 24'd8000000);
        send_sample(16'h0000, 24'd3670016);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering,
    // so the pipeline fills and stalls its input; then the sender waits for drain.
    task automatic test_backpressure();
        write_calibration(16'd1200, 16'd900, 16'd600, 16'd3900);
        send_idle_pct = 0;
        recv_hold_cycles <= 300;
        repeat (120) send_random_sample();
        wait_for_drain();
    endtask

    task automatic test_random_phase(int snd_pct, int rcv_pct, int n_items);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        write_calibration(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
                          16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)));
        repeat (n_items / 2) send_random_sample();
        // Realistic words put the base of the middle term between the outer two.
        write_calibration(16'($urandom_range(3000, 0)), 16'($urandom_range(3000, 0)),
                          16'($urandom_range(3000, 0)), 16'($urandom_range(5800, 1800)));
        repeat (n_items - n_items / 2) send_random_sample();
    endtask

    initial begin
        for (int k = 0; k < 4; k++) cal_words[k] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_zero_divisor();
        test_backpressure();
        test_random_phase(33, 66, 540);
        test_random_phase(66, 33, 540);
        write_calibration(16'd0, 16'd0, 16'd0, 16'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (100) send_random_sample();
        test_random_phase(0, 0, 540);
        wait_for_drain();

        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bpc_pkg.sv
hdl/bpc_div_stage.sv
hdl/baro_pressure_compensation.sv
hdl/bpc_chk.sv
sim/tb_baro_pressure_compensation.sv
